@@ rtl/core/halton_radical_inverse_core_assert.svh @@
// Assertion macros for the radical inverse core.
// The macros expect signals named clk and rst_n in the including scope.
`ifndef HALTON_RADICAL_INVERSE_CORE_ASSERT_SVH
`define HALTON_RADICAL_INVERSE_CORE_ASSERT_SVH

// Same-cycle implication.
`define HRI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("radical inverse core: same-cycle check failed");

// Next-cycle implication.
`define HRI_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("radical inverse core: next-cycle check failed");

`endif

@@ rtl/core/hri_pkg.sv @@
`default_nettype none
package hri_pkg;

  localparam int IDX_W         = 32;
  localparam int RADIX_BITS    = 8;
  localparam int FRACTION_BITS = 24;
  localparam int DEN_W         = IDX_W + RADIX_BITS;
  localparam int MUL_W         = DEN_W + RADIX_BITS;
  localparam int DIV_BITS      = 8;
  localparam int DIV_CYC       = IDX_W / DIV_BITS;
  localparam int CNT_MAX       = (FRACTION_BITS > DIV_CYC) ? FRACTION_BITS : DIV_CYC;
  localparam int CNT_W         = $clog2(CNT_MAX);

  typedef logic [IDX_W-1:0]         index_t;
  typedef logic [RADIX_BITS-1:0]    radix_t;
  typedef logic [FRACTION_BITS-1:0] frac_t;
  typedef logic [DEN_W-1:0]         den_t;
  typedef logic [DIV_BITS-1:0]      digit_bits_t;

endpackage
`default_nettype wire

@@ rtl/core/hri_if.sv @@
`default_nettype none
interface hri_in_if;
  import hri_pkg::*;

  logic   valid;
  logic   ready;
  index_t sample_index;
  radix_t radix;

  modport source (output valid, output sample_index, output radix, input ready);
  modport sink (input valid, input sample_index, input radix, output ready);
endinterface

interface hri_out_if;
  import hri_pkg::*;

  logic  valid;
  logic  ready;
  frac_t fraction;
  logic  bad_radix;

  modport source (output valid, output fraction, output bad_radix, input ready);
  modport sink (input valid, input fraction, input bad_radix, output ready);
endinterface
`default_nettype wire

@@ rtl/core/hri_div_unit.sv @@
`default_nettype none
module hri_div_unit (
  input  wire hri_pkg::radix_t      rem_in,
  input  wire hri_pkg::digit_bits_t dividend_bits,
  input  wire hri_pkg::radix_t      divisor,
  output hri_pkg::radix_t           rem_out,
  output hri_pkg::digit_bits_t      quot_bits
);
  import hri_pkg::*;

  logic [RADIX_BITS:0] trial;
  logic [RADIX_BITS:0] dvs;
  radix_t              rem;

  // Eight restoring division steps; the remainder stays below the divisor when rem_in does.
  always_comb begin
    rem       = rem_in;
    quot_bits = '0;
    trial     = '0;
    dvs       = {1'b0, divisor};
    for (int i = DIV_BITS - 1; i >= 0; i--) begin
      trial = {rem, dividend_bits[i]};
      if (trial >= dvs) begin
        rem          = RADIX_BITS'(trial - dvs);
        quot_bits[i] = 1'b1;
      end else begin
        rem = trial[RADIX_BITS-1:0];
      end
    end
    rem_out = rem;
  end

endmodule
`default_nettype wire

@@ rtl/core/hri_mac_unit.sv @@
`default_nettype none
module hri_mac_unit (
  input  wire hri_pkg::den_t   mul_a,
  input  wire hri_pkg::radix_t mul_b,
  input  wire hri_pkg::radix_t add_c,
  output hri_pkg::den_t        result
);
  import hri_pkg::*;

  logic [MUL_W-1:0] wide;

  // The sequencer guarantees the product fits in DEN_W bits.
  assign wide   = MUL_W'(mul_a) * MUL_W'(mul_b) + MUL_W'(add_c);
  assign result = wide[DEN_W-1:0];

endmodule
`default_nettype wire

@@ rtl/core/halton_radical_inverse_core.sv @@
// The sequencer handles the D radix digits of the index (D from 0 to 32) in turn;
// a radix below two goes straight to the output step. Each digit divides the index
// by the radix on the shared 8-bit-per-cycle divider, then the shared multiplier
// updates numerator and denominator; binary long division of the 24 fraction bits
// and the output step follow. Words are taken only while idle; a stalled result word
// holds the sequencer. Reset (synchronous, active low) idles it and drops the output word.
`default_nettype none
`include "halton_radical_inverse_core_assert.svh"
module halton_radical_inverse_core (
  input wire clk,
  input wire rst_n,
  hri_in_if.sink    in_if,
  hri_out_if.source out_if
);
  import hri_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_MULN = 3'd2;
  localparam logic [2:0] ST_MULD = 3'd3;
  localparam logic [2:0] ST_LDIV = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  index_t           idx_r, idx_nxt;
  radix_t           b_r, b_nxt;
  radix_t           rem_r, rem_nxt;
  den_t             num_r, num_nxt;
  den_t             den_r, den_nxt;
  frac_t            frac_r, frac_nxt;
  logic             bad_r, bad_nxt;
  logic             out_valid_r, out_valid_nxt;
  frac_t            out_frac_r, out_frac_nxt;
  logic             out_bad_r, out_bad_nxt;

  radix_t       div_rem;
  digit_bits_t  div_q;
  den_t         mac_a;
  radix_t       mac_c;
  den_t         mac_res;
  logic [DEN_W:0] ld_shift;
  logic [DEN_W:0] ld_diff;
  logic         ld_ge;
  logic         in_acc;
  logic         load_out;

  hri_div_unit u_div (
    .rem_in       (rem_r),
    .dividend_bits(idx_r[IDX_W-1 -: DIV_BITS]),
    .divisor      (b_r),
    .rem_out      (div_rem),
    .quot_bits    (div_q)
  );

  assign mac_a = (state_r == ST_MULN) ? num_r : den_r;
  assign mac_c = (state_r == ST_MULN) ? rem_r : '0;

  hri_mac_unit u_mac (
    .mul_a (mac_a),
    .mul_b (b_r),
    .add_c (mac_c),
    .result(mac_res)
  );

  assign ld_shift = {num_r, 1'b0};
  assign ld_ge    = ld_shift >= {1'b0, den_r};
  assign ld_diff  = ld_shift - {1'b0, den_r};

  assign in_if.ready      = (state_r == ST_IDLE);
  assign in_acc           = in_if.valid && in_if.ready;
  assign load_out         = (state_r == ST_FIN) && (!out_valid_r || out_if.ready);
  assign out_if.valid     = out_valid_r;
  assign out_if.fraction  = out_frac_r;
  assign out_if.bad_radix = out_bad_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    b_nxt         = b_r;
    rem_nxt       = rem_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    frac_nxt      = frac_r;
    bad_nxt       = bad_r;
    out_frac_nxt  = out_frac_r;
    out_bad_nxt   = out_bad_r;
    out_valid_nxt = out_if.ready ? 1'b0 : out_valid_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          idx_nxt  = in_if.sample_index;
          b_nxt    = in_if.radix;
          rem_nxt  = '0;
          num_nxt  = '0;
          den_nxt  = DEN_W'(1);
          frac_nxt = '0;
          cnt_nxt  = '0;
          if (in_if.radix < RADIX_BITS'(2)) begin
            bad_nxt   = 1'b1;
            state_nxt = ST_FIN;
          end else begin
            bad_nxt   = 1'b0;
            state_nxt = (in_if.sample_index == '0) ? ST_LDIV : ST_DIV;
          end
        end
      end
      ST_DIV: begin
        idx_nxt = {idx_r[IDX_W-DIV_BITS-1:0], div_q};
        rem_nxt = div_rem;
        if (cnt_r == CNT_W'(DIV_CYC - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_MULN;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_MULN: begin
        num_nxt   = mac_res;
        state_nxt = ST_MULD;
      end
      ST_MULD: begin
        den_nxt   = mac_res;
        rem_nxt   = '0;
        state_nxt = (idx_r == '0) ? ST_LDIV : ST_DIV;
      end
      ST_LDIV: begin
        num_nxt  = ld_ge ? ld_diff[DEN_W-1:0] : ld_shift[DEN_W-1:0];
        frac_nxt = {frac_r[FRACTION_BITS-2:0], ld_ge};
        if (cnt_r == CNT_W'(FRACTION_BITS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_FIN: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          out_frac_nxt  = frac_r;
          out_bad_nxt   = bad_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    b_r        <= b_nxt;
    rem_r      <= rem_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    frac_r     <= frac_nxt;
    bad_r      <= bad_nxt;
    out_frac_r <= out_frac_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  `HRI_ASSERT_NXT(a_bad_radix_fin, in_acc && (in_if.radix < RADIX_BITS'(2)), state_r == ST_FIN)
  `HRI_ASSERT_IMP(a_bad_frac_zero, out_valid_r && out_bad_r, out_frac_r == '0)
  `HRI_ASSERT_IMP(a_ldiv_num_lt_den, state_r == ST_LDIV, num_r < den_r)
  `HRI_ASSERT_IMP(a_div_radix_ok, state_r == ST_DIV, (b_r >= RADIX_BITS'(2)) && (rem_r < b_r))

endmodule
`default_nettype wire

@@ bench/tb_halton_radical_inverse_core.sv @@
`timescale 1ns / 100ps
module tb_halton_radical_inverse_core;
  import hri_pkg::*;

  localparam int RANDOM_SAMPLES = 950;
  localparam int DRAIN_CYCLES   = 240;
  localparam int CYCLE_LIMIT    = 1000000;

  typedef struct packed {
    index_t idx;
    radix_t radix;
  } sample_t;

  typedef struct packed {
    frac_t fraction;
    logic  bad_radix;
  } inverse_t;

  logic clk;
  logic rst_n;

  hri_in_if  in_ch ();
  hri_out_if out_ch ();

  halton_radical_inverse_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  sample_t  pending_samples[$];
  inverse_t expected_inverses[$];
  int       mismatches = 0;
  int       cycle_count = 0;
  int       gap_left;
  int       burst_left;
  int       ready_hold;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirrors the index digits about the radix point and truncates the exact ratio.
  function automatic inverse_t radical_inverse(index_t idx, radix_t radix);
    logic [63:0] rest;
    logic [63:0] num;
    logic [63:0] den;
    inverse_t    res;
    rest = idx;
    num  = 0;
    den  = 1;
    res  = '0;
    if (radix < 2) begin
      res.bad_radix = 1'b1;
      return res;
    end
    while (rest > 0) begin
      num  = num * radix + (rest % radix);
      den  = den * radix;
      rest = rest / radix;
    end
    for (int k = 0; k < FRACTION_BITS; k++) begin
      num          = num << 1;
      res.fraction = res.fraction << 1;
      if (num >= den) begin
        num             = num - den;
        res.fraction[0] = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic radix_t pick_radix();
    case ($urandom_range(0, 15))
      0: begin
        return radix_t'($urandom_range(0, 1));
      end
      1, 2, 3, 4, 5, 6: begin
        return radix_t'($urandom_range(2, 16));
      end
      7, 8, 9, 10, 11: begin
        return radix_t'($urandom_range(2, 255));
      end
      default: begin
        return radix_t'($urandom_range(0, 255));
      end
    endcase
  endfunction

  // Powers of the radix and one below them give the longest digit strings.
  function automatic index_t pick_index(radix_t radix);
    logic [63:0] power;
    int          steps;
    power = 1;
    case ($urandom_range(0, 5))
      0: begin
        return index_t'($urandom_range(0, 15));
      end
      1: begin
        return index_t'($urandom_range(0, 5000));
      end
      2: begin
        if (radix < 2) begin
          return index_t'($urandom());
        end
        steps = $urandom_range(1, 32);
        repeat (steps) begin
          if (power * radix <= 64'hFFFF_FFFF) begin
            power = power * radix;
          end
        end
        return index_t'(power - $urandom_range(0, 1));
      end
      3: begin
        return index_t'(1) << $urandom_range(0, 31);
      end
      default: begin
        return index_t'($urandom());
      end
    endcase
  endfunction

  task automatic add_sample(index_t idx, radix_t radix);
    sample_t s;
    s.idx   = idx;
    s.radix = radix;
    pending_samples = {pending_samples, s};
  endtask

  always @(posedge clk) begin : drive_samples
    sample_t next_sample;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left    <= 0;
      burst_left  <= $urandom_range(1, 20);
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left > 0 || pending_samples.size() == 0) begin
        in_ch.valid <= 1'b0;
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end
      end else begin
        next_sample        = pending_samples.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.sample_index <= next_sample.idx;
        in_ch.radix        <= next_sample.radix;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 20);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // The receiver picks random runs of ready and runs of stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      ready_hold   <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 2) != 0) begin
      out_ch.ready <= 1'b1;
      ready_hold   <= $urandom_range(0, 40);
    end else begin
      out_ch.ready <= 1'b0;
      ready_hold   <= $urandom_range(0, 15);
    end
  end

  always @(posedge clk) begin : check_inverses
    inverse_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_inverses = {expected_inverses,
                             radical_inverse(in_ch.sample_index, in_ch.radix)};
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_inverses.size() == 0) begin
          $error("unexpected result word: fraction %0h bad_radix %0b",
                 out_ch.fraction, out_ch.bad_radix);
          mismatches++;
        end else begin
          want = expected_inverses.pop_front();
          if (out_ch.fraction !== want.fraction) begin
            $error("fraction mismatch: expected %0h, actual %0h",
                   want.fraction, out_ch.fraction);
            mismatches++;
          end
          if (out_ch.bad_radix !== want.bad_radix) begin
            $error("bad_radix mismatch: expected %0b, actual %0b",
                   want.bad_radix, out_ch.bad_radix);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_halton_radical_inverse_core failed");
      $finish;
    end
  end

  initial begin
    radix_t r;
    clk   = 1'b0;
    rst_n = 1'b0;

    add_sample(32'd0, 8'd2);
    add_sample(32'd0, 8'd0);
    add_sample(32'd0, 8'd1);
    add_sample(32'hFFFF_FFFF, 8'd0);
    add_sample(32'hFFFF_FFFF, 8'd1);
    add_sample(32'd1, 8'd2);
    add_sample(32'hFFFF_FFFF, 8'd2);
    add_sample(32'hFFFF_FFFF, 8'd3);
    add_sample(32'hFFFF_FFFF, 8'd255);
    add_sample(32'd1, 8'd255);
    add_sample(32'd254, 8'd255);
    add_sample(32'd255, 8'd255);
    add_sample(32'h8000_0000, 8'd2);
    add_sample(32'hAAAA_AAAA, 8'd2);
    add_sample(32'h5555_5555, 8'd3);
    add_sample(32'h1234_5678, 8'd16);
    add_sample(32'hDEAD_BEEF, 8'd10);
    add_sample(32'd1, 8'd3);
    add_sample(32'd2, 8'd3);
    add_sample(32'd65535, 8'd254);
    add_sample(32'd7, 8'd128);
    add_sample(32'd0, 8'd255);
    for (int n = 0; n < RANDOM_SAMPLES; n++) begin
      r = pick_radix();
      add_sample(pick_index(r), r);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_samples.size() != 0 || in_ch.valid || expected_inverses.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_inverses.size() == 0) begin
      $display("tb_halton_radical_inverse_core passed");
    end else begin
      $display("tb_halton_radical_inverse_core failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/hri_pkg.sv
rtl/core/hri_if.sv
rtl/core/hri_div_unit.sv
rtl/core/hri_mac_unit.sv
rtl/core/halton_radical_inverse_core.sv
bench/tb_halton_radical_inverse_core.sv
